// ----- design/wpm_pkg.sv -----
// Shared types, codes and constants for the WAV PCM16 level meter.
`default_nettype none

package wpm_pkg;

  localparam int unsigned FMT_MAX_BYTES_DEF = 32;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] FMT_MIN_BYTES = 32'd16;
  localparam logic [15:0] PCM_BITS = 16'd16;
  localparam logic [15:0] PCM_TAG  = 16'd1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOT_WAV = 2'd1;
  localparam logic [1:0] ST_UNSUP   = 2'd2;

  // Divider runs 80 bits for sum*65536/samples and 31 bits for samples/channels.
  localparam int unsigned DVD_W        = 80;
  localparam int unsigned DIV_RMS_STEPS = 80;
  localparam int unsigned DIV_FR_STEPS  = 31;
  localparam int unsigned SQ_W          = 48;
  localparam int unsigned SQRT_STEPS    = 24;
  localparam int unsigned CNT_W         = 7;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CHUNK,
    PH_FMT,
    PH_SKIP,
    PH_PAD,
    PH_DATA,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    CS_PARSE,
    CS_RMS_LOAD,
    CS_RMS_DIV,
    CS_SQ_LOAD,
    CS_SQRT,
    CS_FR_LOAD,
    CS_FR_DIV,
    CS_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] peak;
    logic [23:0] rms_q8;
    logic [31:0] sample_rate;
    logic [15:0] channel_count;
    logic [30:0] sample_count;
    logic [30:0] frame_count;
  } out_item_t;

  typedef struct packed {
    logic take_byte;
    logic rms_load;
    logic fr_load;
    logic div_step;
    logic sq_load;
    logic sq_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic result_hit;
    logic result_ok;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- design/wpm_ctrl.sv -----
// Sequencer: byte intake, per-file divide and square-root steps, result hold.
`default_nettype none

module wpm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              byte_valid,
  output logic                   byte_stall,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output wpm_pkg::dp_cmd_t       cmd,
  input  wire wpm_pkg::dp_stat_t stat
);
  import wpm_pkg::*;

  ctrl_state_t      state, state_next;
  logic [CNT_W-1:0] cnt;
  logic             out_full;
  logic             last_rms, last_sq, last_fr;

  assign last_rms = (cnt == CNT_W'(DIV_RMS_STEPS - 1));
  assign last_sq  = (cnt == CNT_W'(SQRT_STEPS - 1));
  assign last_fr  = (cnt == CNT_W'(DIV_FR_STEPS - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      CS_PARSE:    if (cmd.take_byte && stat.result_hit) begin
                     state_next = stat.result_ok ? CS_RMS_LOAD : CS_FINISH;
                   end
      CS_RMS_LOAD: state_next = CS_RMS_DIV;
      CS_RMS_DIV:  if (last_rms) state_next = CS_SQ_LOAD;
      CS_SQ_LOAD:  state_next = CS_SQRT;
      CS_SQRT:     if (last_sq) state_next = CS_FR_LOAD;
      CS_FR_LOAD:  state_next = CS_FR_DIV;
      CS_FR_DIV:   if (last_fr) state_next = CS_FINISH;
      CS_FINISH:   if (!out_full) state_next = CS_PARSE;
      default:     state_next = CS_PARSE;
    endcase
  end

  always_comb begin
    cmd = '0;
    byte_stall = 1'b1;
    unique case (state)
      CS_PARSE: begin
        byte_stall = out_full;
        cmd.take_byte = byte_valid && !out_full;
      end
      CS_RMS_LOAD: cmd.rms_load = 1'b1;
      CS_RMS_DIV:  cmd.div_step = 1'b1;
      CS_SQ_LOAD:  cmd.sq_load = 1'b1;
      CS_SQRT:     cmd.sq_step = 1'b1;
      CS_FR_LOAD:  cmd.fr_load = 1'b1;
      CS_FR_DIV:   cmd.div_step = 1'b1;
      CS_FINISH:   cmd.out_load = !out_full;
      default:     cmd = '0;
    endcase
  end

  assign result_valid = out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_PARSE;
      cnt <= '0;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.rms_load || cmd.sq_load || cmd.fr_load) begin
        cnt <= '0;
      end else begin
        cnt <= cnt + CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_full <= 1'b1;
      end else if (!result_stall) begin
        out_full <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/wpm_dp.sv -----
// Datapath: chunk parser, sample statistics, shared divider, square root, result register.
`default_nettype none

module wpm_dp #(
  parameter int unsigned FMT_MAX_BYTES = wpm_pkg::FMT_MAX_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire wpm_pkg::in_item_t  item,
  input  wire wpm_pkg::dp_cmd_t   cmd,
  output wpm_pkg::dp_stat_t       stat,
  output wpm_pkg::out_item_t      result
);
  import wpm_pkg::*;

  // parser state
  phase_t      phase, phase_next;
  logic [31:0] idx, idx_next, tag, tag_next, size, size_next;
  logic [15:0] chan, chan_next, bits, bits_next;
  logic [31:0] rate, rate_next;
  logic [30:0] left, left_next;
  logic [7:0]  low, low_next;
  logic [16:0] peak, peak_next;
  logic [63:0] sum, sum_next;
  logic        hit;
  logic [1:0]  code;
  logic [31:0] idx_inc;
  logic [15:0] smp;
  logic [16:0] mag;
  logic [33:0] sq;
  logic [7:0]  b;

  // captured file result
  logic [1:0]  snap_status;
  logic [15:0] snap_peak, snap_chan;
  logic [31:0] snap_rate;
  logic [30:0] snap_samples;
  logic [63:0] snap_sum;
  out_item_t   result_next;

  // divider and root
  logic [DVD_W-1:0] dvd;
  logic [31:0]      rem, rem_sh, rem_sub;
  logic [30:0]      dvs;
  logic [SQ_W-1:0]  sq_v, sq_res, sq_bit, sq_try;

  assign b = item.data_byte;
  assign idx_inc = idx + 32'd1;
  assign smp = {b, low};
  assign mag = smp[15] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
  assign sq = mag * mag;

  always_comb begin
    phase_next = phase; idx_next = idx; tag_next = tag; size_next = size;
    chan_next = chan; bits_next = bits; rate_next = rate; left_next = left;
    low_next = low; peak_next = peak; sum_next = sum;
    hit = 1'b0; code = ST_OK;
    unique case (phase)
      PH_HEADER: begin
        if (idx < 32'd4) begin
          tag_next[{idx[1:0], 3'b000} +: 8] = b;
        end else if (idx >= 32'd8 && idx < 32'd12) begin
          size_next[{idx[1:0], 3'b000} +: 8] = b;
        end
        idx_next = idx_inc;
        if (idx == 32'd11) begin
          if (tag_next == TAG_RIFF && size_next == TAG_WAVE) begin
            phase_next = PH_CHUNK; idx_next = '0; tag_next = '0; size_next = '0;
          end else begin
            hit = 1'b1; code = ST_NOT_WAV;
          end
        end
      end
      PH_CHUNK: begin
        if (idx < 32'd4) begin
          tag_next[{idx[1:0], 3'b000} +: 8] = b;
        end else if (idx < 32'd8) begin
          size_next[{idx[1:0], 3'b000} +: 8] = b;
        end
        idx_next = idx_inc;
        if (idx == 32'd7) begin
          idx_next = '0;
          if (tag_next == TAG_FMT) begin
            if (size_next < FMT_MIN_BYTES || size_next > 32'(FMT_MAX_BYTES)) begin
              hit = 1'b1; code = ST_UNSUP;
            end else begin
              phase_next = PH_FMT; tag_next = '0;
              chan_next = '0; rate_next = '0; bits_next = '0;
            end
          end else if (tag_next == TAG_DATA) begin
            if (chan == '0 || rate == '0 || bits != PCM_BITS || size_next == '0) begin
              hit = 1'b1; code = ST_UNSUP;
            end else begin
              left_next = size_next[31:1];
              peak_next = '0;
              sum_next = '0;
              if (size_next[31:1] == '0) begin
                hit = 1'b1; code = ST_OK;
              end else begin
                phase_next = PH_DATA;
              end
            end
          end else if (size_next == '0) begin
            phase_next = PH_CHUNK; tag_next = '0; size_next = '0;
          end else begin
            phase_next = PH_SKIP;
          end
        end
      end
      PH_FMT: begin
        if (idx < 32'd2) begin
          tag_next[{idx[0], 3'b000} +: 8] = b;
        end else if (idx < 32'd4) begin
          chan_next[{idx[0], 3'b000} +: 8] = b;
        end else if (idx < 32'd8) begin
          rate_next[{idx[1:0], 3'b000} +: 8] = b;
        end else if (idx == 32'd14 || idx == 32'd15) begin
          bits_next[{idx[0], 3'b000} +: 8] = b;
        end
        idx_next = idx_inc;
        if (idx_inc >= size) begin
          if (tag_next[15:0] != PCM_TAG) begin
            hit = 1'b1; code = ST_UNSUP;
          end else if (size[0]) begin
            phase_next = PH_PAD;
          end else begin
            phase_next = PH_CHUNK; idx_next = '0; tag_next = '0; size_next = '0;
          end
        end
      end
      PH_SKIP: begin
        idx_next = idx_inc;
        if (idx_inc >= size) begin
          if (size[0]) begin
            phase_next = PH_PAD;
          end else begin
            phase_next = PH_CHUNK; idx_next = '0; tag_next = '0; size_next = '0;
          end
        end
      end
      PH_PAD: begin
        phase_next = PH_CHUNK; idx_next = '0; tag_next = '0; size_next = '0;
      end
      PH_DATA: begin
        if (!idx[0]) begin
          low_next = b;
        end else begin
          if (mag > peak) peak_next = mag;
          sum_next = sum + 64'(sq);
          left_next = left - 31'd1;
          if (left_next == '0) begin
            hit = 1'b1; code = ST_OK;
          end
        end
        idx_next = {31'd0, ~idx[0]};
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase
    if (hit) phase_next = PH_DONE;
    // end of file closes an unfinished file
    if (item.end_of_file && !hit && phase != PH_DONE) begin
      hit = 1'b1;
      if (phase_next == PH_HEADER) code = ST_NOT_WAV;
      else if (phase_next == PH_DATA) code = ST_OK;
      else code = ST_UNSUP;
    end
  end

  assign stat.result_hit = hit;
  assign stat.result_ok = (code == ST_OK);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER; idx <= '0; tag <= '0; size <= '0; chan <= '0;
      bits <= '0; rate <= '0; left <= '0; low <= '0; peak <= '0; sum <= '0;
    end else if (cmd.take_byte) begin
      if (item.end_of_file) begin
        phase <= PH_HEADER; idx <= '0; tag <= '0; size <= '0; chan <= '0;
        bits <= '0; rate <= '0; left <= '0; low <= '0; peak <= '0; sum <= '0;
      end else begin
        phase <= phase_next; idx <= idx_next; tag <= tag_next; size <= size_next;
        chan <= chan_next; bits <= bits_next; rate <= rate_next; left <= left_next;
        low <= low_next; peak <= peak_next; sum <= sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte && hit) begin
      snap_status <= code;
      snap_peak <= peak_next[15:0];
      snap_rate <= rate_next;
      snap_chan <= chan_next;
      snap_samples <= size_next[31:1];
      snap_sum <= sum_next;
    end
  end

  // restoring divider, one quotient bit per step; quotient shifts into dvd
  assign rem_sh = {rem[30:0], dvd[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (cmd.rms_load) begin
      dvd <= {snap_sum, 16'd0};
      dvs <= snap_samples;
      rem <= '0;
    end else if (cmd.fr_load) begin
      dvd <= {snap_samples, (DVD_W - 31)'(0)};
      dvs <= {15'd0, snap_chan};
      rem <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, dvs}) begin
        rem <= rem_sub;
        dvd <= {dvd[DVD_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        dvd <= {dvd[DVD_W-2:0], 1'b0};
      end
    end
  end

  // bit-pair integer square root
  assign sq_try = sq_res + sq_bit;

  always_ff @(posedge clk) begin
    if (cmd.sq_load) begin
      sq_v <= dvd[SQ_W-1:0];
      sq_res <= '0;
      sq_bit <= SQ_W'(1) << (SQ_W - 2);
    end else if (cmd.sq_step) begin
      if (sq_v >= sq_try) begin
        sq_v <= sq_v - sq_try;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  // failures carry only their status
  always_comb begin
    result_next = '0;
    result_next.status = snap_status;
    if (snap_status == ST_OK) begin
      result_next.peak = snap_peak;
      result_next.rms_q8 = (snap_samples == '0) ? 24'd0 : sq_res[23:0];
      result_next.sample_rate = snap_rate;
      result_next.channel_count = snap_chan;
      result_next.sample_count = snap_samples;
      result_next.frame_count = (snap_chan == '0) ? 31'd0 : dvd[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/wav_pcm16_level_meter.sv -----
// Top level of the WAV PCM16 level meter: sequencer plus datapath.
// Parsing takes one byte per cycle while no result is pending.
// A failed file goes from its deciding byte straight to the finish step; a good
// file first runs an 80-step mean-square divide, 24-step root, 31-step frame divide.
// Input stalls from the deciding byte until the result transfer completes.
// rst is synchronous: parser returns to the header phase with cleared sums.
`default_nettype none

module wav_pcm16_level_meter #(
  parameter int unsigned FMT_MAX_BYTES = wpm_pkg::FMT_MAX_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               byte_valid,
  output logic                    byte_stall,
  input  wire wpm_pkg::in_item_t  byte_item,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output wpm_pkg::out_item_t      result_item
);
  import wpm_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer: decide when a byte transfers and walk the per-file math.
  wpm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .cmd          (cmd),
    .stat         (stat)
  );

  // Datapath: chunk walk, peak and square sum, divide, root, result hold.
  wpm_dp #(
    .FMT_MAX_BYTES (FMT_MAX_BYTES)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (byte_item),
    .cmd    (cmd),
    .stat   (stat),
    .result (result_item)
  );

endmodule

`default_nettype wire

// ----- design/wpm_checker.sv -----
// Port-level checks for the WAV PCM16 level meter, bound to the top level.
`default_nettype none

module wpm_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               byte_stall,
  input wire logic               result_valid,
  input wire logic               result_stall,
  input wire wpm_pkg::out_item_t result_item
);
  import wpm_pkg::*;

  // a held result stays up
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // no byte transfer while a result waits
  a_seq: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> byte_stall)
    else $error("byte taken with result pending");

  // failures carry no measurements
  a_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.status != ST_OK |->
      result_item.peak == '0 && result_item.rms_q8 == '0 &&
      result_item.sample_count == '0 && result_item.frame_count == '0)
    else $error("failure result carries data");

  a_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_item.status <= ST_UNSUP)
    else $error("bad status code");

  a_frames: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.status == ST_OK |->
      result_item.frame_count <= result_item.sample_count)
    else $error("frames exceed samples");

endmodule

bind wav_pcm16_level_meter wpm_checker u_chk (.*);

`default_nettype wire
